FILE: src/mhpq_pkg.sv
// Shared types, constants and codes for the max-heap priority queue.
package mhpq_pkg;

	// Heap geometry
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CHILD_W  = IDX_W + 2;

	// Field widths
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 7;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	// Request kinds
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam data_t EMPTY_VALUE = -32'sd1;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_POP_RD0,
		S_POP_RD1,
		S_POP_LAST,
		S_DN_RDL,
		S_DN_RDR,
		S_DN_CMP,
		S_DONE
	} state_t;

	// Heap store access as driven by the sequencer
	typedef struct packed {
		logic  we;
		idx_t  waddr;
		data_t wdata;
		idx_t  raddr;
	} ram_req_t;

	// One result as produced by the sequencer
	typedef struct packed {
		data_t                popped_value;
		status_t              status;
		logic [COUNT_W-1:0]   entry_count;
	} result_t;

endpackage

FILE: src/mhpq_req_if.sv
// Request channel: push or pop with the value to push.
interface mhpq_req_if;
	import mhpq_pkg::*;

	logic  valid;
	logic  ready;
	logic  req_type;
	data_t push_value;

	modport source (output valid, req_type, push_value, input ready);
	modport sink   (input valid, req_type, push_value, output ready);
endinterface

FILE: src/mhpq_res_if.sv
// Result channel: popped value, status and entry count.
interface mhpq_res_if;
	import mhpq_pkg::*;

	logic                 valid;
	logic                 ready;
	data_t                popped_value;
	logic [1:0]           status;
	logic [COUNT_W-1:0]   entry_count;

	modport source (output valid, popped_value, status, entry_count, input ready);
	modport sink   (input valid, popped_value, status, entry_count, output ready);
endinterface

FILE: src/mhpq_ram.sv
// Heap store: one write port and one registered read port.
module mhpq_ram (
	input  logic               clk,
	input  mhpq_pkg::ram_req_t ram_req,
	output mhpq_pkg::data_t    rdata
);
	import mhpq_pkg::*;

	data_t mem_q [CAPACITY];

	// Write port
	always_ff @(posedge clk) begin
		if (ram_req.we) begin
			mem_q[ram_req.waddr] <= ram_req.wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[ram_req.raddr];
	end

endmodule

FILE: src/mhpq_ctrl.sv
// Sift sequencer: walks the heap one level at a time through the heap store's write and read ports.
module mhpq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic               req_type,
	input  mhpq_pkg::data_t    push_value,
	output mhpq_pkg::ram_req_t ram_req,
	input  mhpq_pkg::data_t    rdata,
	output logic               res_valid,
	input  logic               res_ready,
	output mhpq_pkg::result_t  result
);
	import mhpq_pkg::*;

	state_t  state_q, state_d;
	idx_t    pos_q;
	cnt_t    cnt_q;
	data_t   val_q;
	data_t   left_q;
	data_t   res_val_q;
	status_t res_st_q;

	logic [CHILD_W-1:0] l_idx, r_idx, n_ext;
	idx_t  parent_idx;
	idx_t  pick_idx;
	data_t pick_val;
	logic  has_l, has_r, pick_r;
	logic  full, empty;
	logic  parent_lt, val_lt_pick;

	// Index arithmetic
	assign parent_idx = (pos_q - idx_t'(1)) >> 1;
	assign l_idx      = CHILD_W'({pos_q, 1'b1});
	assign r_idx      = l_idx + CHILD_W'(1);
	assign n_ext      = CHILD_W'(cnt_q);
	assign has_l      = l_idx < n_ext;
	assign has_r      = r_idx < n_ext;
	assign full       = cnt_q == cnt_t'(CAPACITY);
	assign empty      = cnt_q == '0;

	// Comparators: parent vs moving value, children, moving value vs chosen child
	assign parent_lt   = rdata < val_q;
	assign pick_r      = has_r && !(rdata < left_q);
	assign pick_val    = pick_r ? rdata : left_q;
	assign pick_idx    = pick_r ? r_idx[IDX_W-1:0] : l_idx[IDX_W-1:0];
	assign val_lt_pick = val_q < pick_val;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req_type == REQ_PUSH) begin
						state_d = full ? S_DONE : S_UP_RD;
					end else begin
						state_d = empty ? S_DONE : S_POP_RD0;
					end
				end
			end
			S_UP_RD:    state_d = (pos_q == '0) ? S_DONE : S_UP_CMP;
			S_UP_CMP:   state_d = parent_lt ? S_UP_RD : S_DONE;
			S_POP_RD0:  state_d = S_POP_RD1;
			S_POP_RD1:  state_d = S_POP_LAST;
			S_POP_LAST: state_d = empty ? S_DONE : S_DN_RDL;
			S_DN_RDL:   state_d = has_l ? S_DN_RDR : S_DONE;
			S_DN_RDR:   state_d = S_DN_CMP;
			S_DN_CMP:   state_d = val_lt_pick ? S_DN_RDL : S_DONE;
			S_DONE:     state_d = res_ready ? S_IDLE : S_DONE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Outputs: store access and handshakes
	always_comb begin
		ram_req       = '0;
		ram_req.wdata = val_q;
		ram_req.waddr = pos_q;
		req_ready     = 1'b0;
		res_valid     = 1'b0;
		unique case (state_q)
			S_IDLE:     req_ready = 1'b1;
			S_UP_RD: begin
				ram_req.raddr = parent_idx;
				ram_req.we    = pos_q == '0;
			end
			S_UP_CMP: begin
				ram_req.we = 1'b1;
				if (parent_lt) begin
					ram_req.wdata = rdata;
				end
			end
			S_POP_RD0:  ram_req.raddr = '0;
			S_POP_RD1:  ram_req.raddr = cnt_q[IDX_W-1:0];
			S_POP_LAST: ram_req.raddr = '0;
			S_DN_RDL: begin
				ram_req.raddr = l_idx[IDX_W-1:0];
				ram_req.we    = !has_l;
			end
			S_DN_RDR:   ram_req.raddr = r_idx[IDX_W-1:0];
			S_DN_CMP: begin
				ram_req.we = 1'b1;
				if (val_lt_pick) begin
					ram_req.wdata = pick_val;
				end
			end
			S_DONE:     res_valid = 1'b1;
			default:    ram_req = '0;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && req_valid) begin
				if (req_type == REQ_PUSH && !full) begin
					cnt_q <= cnt_q + cnt_t'(1);
				end else if (req_type == REQ_POP && !empty) begin
					cnt_q <= cnt_q - cnt_t'(1);
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				val_q     <= push_value;
				pos_q     <= cnt_q[IDX_W-1:0];
				res_val_q <= '0;
				res_st_q  <= ST_DONE;
				if (req_type == REQ_PUSH && full) begin
					res_st_q <= ST_FULL;
				end else if (req_type == REQ_POP && empty) begin
					res_val_q <= EMPTY_VALUE;
					res_st_q  <= ST_EMPTY;
				end
			end
			S_UP_CMP: begin
				if (parent_lt) begin
					pos_q <= parent_idx;
				end
			end
			S_POP_RD1:  res_val_q <= rdata;
			S_POP_LAST: begin
				val_q <= rdata;
				pos_q <= '0;
			end
			S_DN_RDR:   left_q <= rdata;
			S_DN_CMP: begin
				if (val_lt_pick) begin
					pos_q <= pick_idx;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.popped_value = res_val_q;
	assign result.status       = res_st_q;
	assign result.entry_count  = COUNT_W'(cnt_q);

endmodule

FILE: src/max_heap_priority_queue_core.sv
// Top level of the max-heap priority queue: sequencer, heap store and result register.
//
// A binary max-heap of up to 64 signed 32-bit entries. Each request is a push or a pop and
// yields one result with the popped value, a status and the entry count after the request.
// Requests are taken one at a time. A push climbs from the new last slot, moving each parent
// down while it is smaller than the new value, up to the root. A pop takes the root, moves the
// last entry to the root and sinks it, moving the larger child up while it is larger than the
// moved entry. Pops on an empty heap and pushes to a full one finish without touching the heap
// store. The sequencer holds a finished result until the result register can take it; it then
// waits in that output register, so the next request is taken while it is pending.
module max_heap_priority_queue_core (
	input  logic        clk,
	input  logic        arst_n,
	mhpq_req_if.sink    req,
	mhpq_res_if.source  res
);
	import mhpq_pkg::*;

	ram_req_t ram_req;
	data_t    rdata;
	logic     res_valid;
	logic     res_ready;
	result_t  result;
	logic     out_valid_q;
	result_t  out_q;

	mhpq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.req_type   (req.req_type),
		.push_value (req.push_value),
		.ram_req    (ram_req),
		.rdata      (rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.result     (result)
	);

	mhpq_ram u_ram (
		.clk     (clk),
		.ram_req (ram_req),
		.rdata   (rdata)
	);

	// Result register: loads when empty or being drained
	assign res_ready = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= result;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.popped_value = out_q.popped_value;
	assign res.status       = out_q.status;
	assign res.entry_count  = out_q.entry_count;

endmodule
